### rtl/core/qft_pkg.sv
// Shared types and constants of the quoted field tokenizer.
// No dependencies; every module of the tokenizer imports this package.
package qft_pkg;

    // Default sizing handed to the top level parameters.
    localparam int LINE_MAX_DEF   = 1024;
    localparam int MAX_FIELDS_DEF = 64;

    // Fixed widths of the payload ports.
    localparam int CH_W     = 8;
    localparam int START_W  = 10;
    localparam int LEN_W    = 10;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_A          = 3'd0,
        REG_DELIM_B          = 3'd1,
        REG_DELIM_C          = 3'd2,
        REG_DELIM_D          = 3'd3,
        REG_DROP_EMPTY       = 3'd4,
        REG_STRIP_QUOTES     = 3'd5,
        REG_KEEP_FINAL_EMPTY = 3'd6
    } qft_reg_idx_t;

    localparam logic [CH_W-1:0] QUOTE_CH = 8'd34;
    localparam logic [CH_W-1:0] EOL_CH   = 8'd0;

    typedef struct packed {
        logic [CH_W-1:0] delim_a;
        logic [CH_W-1:0] delim_b;
        logic [CH_W-1:0] delim_c;
        logic [CH_W-1:0] delim_d;
        logic            drop_empty;
        logic            strip_quotes;
        logic            keep_final_empty;
    } qft_cfg_t;

    typedef struct packed {
        logic               field_valid;
        logic [START_W-1:0] field_start;
        logic [LEN_W-1:0]   field_length;
        logic [INDEX_W-1:0] field_index;
        logic               line_done;
        logic [COUNT_W-1:0] field_count;
        logic               overflow;
    } qft_result_t;

endpackage

### rtl/core/qft_cfg.sv
// Configuration registers of the quoted field tokenizer.
// Depends on qft_pkg.
module qft_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [qft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qft_pkg::CFG_DATA_W-1:0] cfg_data,
    output qft_pkg::qft_cfg_t              cfg
);
    import qft_pkg::*;

    qft_cfg_t cfg_reg;
    qft_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (qft_reg_idx_t'(cfg_index))
                REG_DELIM_A:          cfg_next.delim_a          = cfg_data;
                REG_DELIM_B:          cfg_next.delim_b          = cfg_data;
                REG_DELIM_C:          cfg_next.delim_c          = cfg_data;
                REG_DELIM_D:          cfg_next.delim_d          = cfg_data;
                REG_DROP_EMPTY:       cfg_next.drop_empty       = cfg_data[0];
                REG_STRIP_QUOTES:     cfg_next.strip_quotes     = cfg_data[0];
                REG_KEEP_FINAL_EMPTY: cfg_next.keep_final_empty = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delim_a          <= 8'd32;
            cfg_reg.delim_b          <= 8'd10;
            cfg_reg.delim_c          <= 8'd0;
            cfg_reg.delim_d          <= 8'd0;
            cfg_reg.drop_empty       <= 1'b1;
            cfg_reg.strip_quotes     <= 1'b1;
            cfg_reg.keep_final_empty <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/qft_scan.sv
// Input register, per-line scanner state and field result logic.
// Depends on qft_pkg; feeds qft_outq.
module qft_scan #(
    parameter int LINE_MAX   = qft_pkg::LINE_MAX_DEF,
    parameter int MAX_FIELDS = qft_pkg::MAX_FIELDS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qft_pkg::qft_cfg_t        cfg,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [qft_pkg::CH_W-1:0] ch,
    input  logic                     room,
    output logic                     push,
    output qft_pkg::qft_result_t     result
);
    import qft_pkg::*;

    localparam int POS_W    = $clog2(LINE_MAX);
    localparam int FS_W     = $clog2(MAX_FIELDS + 1);
    localparam int WIDE_W   = (POS_W + 1 > START_W) ? POS_W + 1 : START_W;
    localparam int FSWIDE_W = (FS_W > COUNT_W) ? FS_W : COUNT_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_MAX - 1);
    localparam logic [FS_W-1:0]  FS_MAX   = FS_W'(MAX_FIELDS);

    // input register
    logic            hold_vld_reg;
    logic [CH_W-1:0] ch_reg;
    logic            fire;

    // line state
    logic [POS_W-1:0] position_reg,       position_next;
    logic [POS_W-1:0] field_begin_reg,    field_begin_next;
    logic             quote_first_reg,    quote_first_next;
    logic             inside_quotes_reg,  inside_quotes_next;
    logic             close_pending_reg,  close_pending_next;
    logic [POS_W-1:0] close_position_reg, close_position_next;
    logic [FS_W-1:0]  fields_seen_reg,    fields_seen_next;
    logic             overflowed_reg,     overflowed_next;
    logic             stripped_reg,       stripped_next;

    logic              is_eol, is_quote, is_delim, at_limit, nonempty, kept;
    logic              strip_now, strip_eff, emit_strip, quote_first_eff;
    logic [WIDE_W-1:0] pos_w, fb_w, fb1_w, cp_w, start_w, len_w;
    logic [FS_W-1:0]   fs_plus;
    logic [FSWIDE_W-1:0] idx_w, cnt_w;

    assign fire     = hold_vld_reg && room;
    assign in_stall = hold_vld_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            hold_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            hold_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg <= ch;
        end
    end

    // character classes
    assign is_eol   = (ch_reg == EOL_CH);
    assign is_quote = (ch_reg == QUOTE_CH);
    assign is_delim = !is_eol && (ch_reg == cfg.delim_a || ch_reg == cfg.delim_b ||
                                  ch_reg == cfg.delim_c || ch_reg == cfg.delim_d);
    assign at_limit = (position_reg == LAST_POS);
    assign nonempty = (position_reg != field_begin_reg);
    assign kept     = (fields_seen_reg < FS_MAX);

    // a closing quote is confirmed by a delimiter or by the line end
    assign strip_now       = close_pending_reg && is_delim;
    assign strip_eff       = stripped_reg || strip_now;
    assign quote_first_eff = quote_first_reg && !strip_now;
    assign emit_strip      = is_eol ? (stripped_reg || close_pending_reg) : strip_eff;

    // field span
    assign pos_w   = WIDE_W'(position_reg);
    assign fb_w    = WIDE_W'(field_begin_reg);
    assign fb1_w   = fb_w + WIDE_W'(1);
    assign cp_w    = WIDE_W'(close_position_reg);
    assign start_w = emit_strip ? fb1_w : fb_w;
    assign len_w   = emit_strip ? ((cp_w >= fb1_w) ? cp_w - fb1_w : '0) : pos_w - fb_w;
    assign fs_plus = fields_seen_reg + FS_W'(1);
    assign idx_w   = FSWIDE_W'(fields_seen_reg);

    always_comb
    begin
        position_next       = position_reg;
        field_begin_next    = field_begin_reg;
        quote_first_next    = quote_first_reg;
        inside_quotes_next  = inside_quotes_reg;
        close_pending_next  = close_pending_reg;
        close_position_next = close_position_reg;
        fields_seen_next    = fields_seen_reg;
        overflowed_next     = overflowed_reg;
        stripped_next       = stripped_reg;
        result              = '0;
        push                = 1'b0;
        cnt_w               = '0;

        if (fire)
        begin
            if (is_eol)
            begin
                if (emit_strip || nonempty || cfg.keep_final_empty)
                begin
                    if (kept)
                    begin
                        result.field_valid  = 1'b1;
                        result.field_start  = start_w[START_W-1:0];
                        result.field_length = len_w[LEN_W-1:0];
                        result.field_index  = idx_w[INDEX_W-1:0];
                        cnt_w               = FSWIDE_W'(fs_plus);
                    end
                    else
                    begin
                        cnt_w = FSWIDE_W'(fields_seen_reg);
                    end
                    result.overflow = overflowed_reg || !kept;
                end
                else
                begin
                    cnt_w           = FSWIDE_W'(fields_seen_reg);
                    result.overflow = overflowed_reg;
                end
                result.line_done   = 1'b1;
                result.field_count = cnt_w[COUNT_W-1:0];
                push               = 1'b1;
                position_next       = '0;
                field_begin_next    = '0;
                quote_first_next    = 1'b0;
                inside_quotes_next  = 1'b0;
                close_pending_next  = 1'b0;
                close_position_next = '0;
                fields_seen_next    = '0;
                overflowed_next     = 1'b0;
                stripped_next       = 1'b0;
            end
            else if (!at_limit)
            begin
                close_pending_next = 1'b0;
                stripped_next      = strip_eff;
                quote_first_next   = quote_first_eff;
                if (inside_quotes_reg)
                begin
                    if (is_quote)
                    begin
                        inside_quotes_next = 1'b0;
                        if (cfg.strip_quotes && quote_first_eff && !strip_eff)
                        begin
                            close_pending_next  = 1'b1;
                            close_position_next = position_reg;
                        end
                    end
                end
                else if (is_quote)
                begin
                    if (!nonempty && !strip_eff)
                    begin
                        quote_first_next = 1'b1;
                    end
                    inside_quotes_next = 1'b1;
                end
                else if (is_delim)
                begin
                    if (strip_eff || nonempty || !cfg.drop_empty)
                    begin
                        if (kept)
                        begin
                            result.field_valid  = 1'b1;
                            result.field_start  = start_w[START_W-1:0];
                            result.field_length = len_w[LEN_W-1:0];
                            result.field_index  = idx_w[INDEX_W-1:0];
                            fields_seen_next    = fs_plus;
                            push                = 1'b1;
                        end
                        else
                        begin
                            overflowed_next = 1'b1;
                        end
                    end
                    field_begin_next = position_reg + POS_W'(1);
                    quote_first_next = 1'b0;
                    stripped_next    = 1'b0;
                end
                position_next = position_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg       <= '0;
            field_begin_reg    <= '0;
            quote_first_reg    <= 1'b0;
            inside_quotes_reg  <= 1'b0;
            close_pending_reg  <= 1'b0;
            close_position_reg <= '0;
            fields_seen_reg    <= '0;
            overflowed_reg     <= 1'b0;
            stripped_reg       <= 1'b0;
        end
        else
        begin
            position_reg       <= position_next;
            field_begin_reg    <= field_begin_next;
            quote_first_reg    <= quote_first_next;
            inside_quotes_reg  <= inside_quotes_next;
            close_pending_reg  <= close_pending_next;
            close_position_reg <= close_position_next;
            fields_seen_reg    <= fields_seen_next;
            overflowed_reg     <= overflowed_next;
            stripped_reg       <= stripped_next;
        end
    end

endmodule

### rtl/core/qft_outq.sv
// Two-entry result queue: output register plus skid slot.
// Depends on qft_pkg.
module qft_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  qft_pkg::qft_result_t din,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qft_pkg::qft_result_t dout
);
    import qft_pkg::*;

    localparam logic [1:0] OCC_EMPTY = 2'd0;
    localparam logic [1:0] OCC_ONE   = 2'd1;
    localparam logic [1:0] OCC_FULL  = 2'd2;

    logic [1:0]  occ_reg, occ_next;
    qft_result_t head_reg, head_next;
    qft_result_t skid_reg, skid_next;
    logic        pop;

    assign out_valid = (occ_reg != OCC_EMPTY);
    assign room      = (occ_reg != OCC_FULL);
    assign pop       = out_valid && !out_stall;
    assign dout      = head_reg;

    always_comb
    begin
        occ_next  = occ_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        priority if (occ_reg == OCC_EMPTY)
        begin
            if (push)
            begin
                head_next = din;
                occ_next  = OCC_ONE;
            end
        end
        else if (occ_reg == OCC_ONE)
        begin
            if (push && pop)
            begin
                head_next = din;
            end
            else if (push)
            begin
                skid_next = din;
                occ_next  = OCC_FULL;
            end
            else if (pop)
            begin
                occ_next = OCC_EMPTY;
            end
        end
        else
        begin
            if (pop)
            begin
                head_next = skid_reg;
                occ_next  = OCC_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= OCC_EMPTY;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/core/quoted_field_tokenizer.sv
// Quoted field tokenizer, top level. Path: a transfer on the input is captured in the
// input register, then the scan logic writes its result into the result queue.
// Throughput: one character per cycle; the input
// register holds only while the two-entry result queue is full.
// Reset (rst_n, async, active low) loads the register defaults, clears the line
// state and empties the result queue. Depends on qft_pkg, qft_cfg, qft_scan, qft_outq.
module quoted_field_tokenizer #(
    parameter int LINE_MAX   = qft_pkg::LINE_MAX_DEF,
    parameter int MAX_FIELDS = qft_pkg::MAX_FIELDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write,
    input  logic [qft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qft_pkg::CFG_DATA_W-1:0]    cfg_data,
    // character input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [qft_pkg::CH_W-1:0]          ch,
    // field results
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              field_valid,
    output logic [qft_pkg::START_W-1:0]       field_start,
    output logic [qft_pkg::LEN_W-1:0]         field_length,
    output logic [qft_pkg::INDEX_W-1:0]       field_index,
    output logic                              line_done,
    output logic [qft_pkg::COUNT_W-1:0]       field_count,
    output logic                              overflow
);
    import qft_pkg::*;

    qft_cfg_t    cfg;
    qft_result_t scan_result;
    qft_result_t head;
    logic        push;
    logic        room;

    // Delimiter set and mode bits; the user must write them only while idle, the block does not enforce it.
    qft_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // One character per transfer: quote tracking, pending strip decision and
    // field bookkeeping all settle combinationally from the input register.
    qft_scan #(
        .LINE_MAX   (LINE_MAX),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .room     (room),
        .push     (push),
        .result   (scan_result)
    );

    // Output register plus skid slot, so the scanner keeps taking characters
    // while a result waits to be transferred.
    qft_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (scan_result),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dout      (head)
    );

    assign field_valid  = head.field_valid;
    assign field_start  = head.field_start;
    assign field_length = head.field_length;
    assign field_index  = head.field_index;
    assign line_done    = head.line_done;
    assign field_count  = head.field_count;
    assign overflow     = head.overflow;

    // Line totals only appear on the line end result.
    a_totals_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_done |-> field_count == '0 && !overflow)
        else $error("line totals outside line end");

    // A mid-line result always carries a field.
    a_midline_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_done |-> field_valid)
        else $error("empty result before line end");

    // Results without a field carry zero span and index.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !field_valid |->
            field_start == '0 && field_length == '0 && field_index == '0)
        else $error("span on a result without field");

    // The scanner never writes a result into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("result written into full queue");

endmodule

### tb/tb_quoted_field_tokenizer.sv
// Self-checking testbench for quoted_field_tokenizer: directed and random lines,
// several register settings, random idle on both channels. Depends on qft_pkg and the RTL.
module tb_quoted_field_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import qft_pkg::*;

    localparam int LINE_LIMIT  = LINE_MAX_DEF;
    localparam int FIELD_LIMIT = MAX_FIELDS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    // Clock, reset and every block input start at a known value.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [CH_W-1:0]       ch        = EOL_CH;
    logic                  out_stall = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  field_valid;
    logic [START_W-1:0]    field_start;
    logic [LEN_W-1:0]      field_length;
    logic [INDEX_W-1:0]    field_index;
    logic                  line_done;
    logic [COUNT_W-1:0]    field_count;
    logic                  overflow;

    quoted_field_tokenizer #(
        .LINE_MAX   (LINE_LIMIT),
        .MAX_FIELDS (FIELD_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_valid  (field_valid),
        .field_start  (field_start),
        .field_length (field_length),
        .field_index  (field_index),
        .line_done    (line_done),
        .field_count  (field_count),
        .overflow     (overflow)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Tokenizer predictor: register copy plus the per-line scan state.
    // ------------------------------------------------------------------
    qft_cfg_t    shadow_cfg;
    logic [10:0] scan_pos;        // offset of the next character in the line
    logic [9:0]  fld_begin;       // offset where the current field starts
    logic        quoted_open;     // current field opened with a quote
    logic        in_quote;        // between quotes, delimiters are plain text
    logic        close_wait;      // closing quote seen, next char decides the strip
    logic [9:0]  close_at;        // offset of that closing quote
    logic [6:0]  kept_fields;
    logic        dropped_fields;
    logic        quotes_removed;  // current field stripped, content frozen

    qft_result_t field_q[$];      // expected results, oldest first
    logic [7:0]  pending_chars[$];// characters not yet handed to the driver
    int          queued;
    int          mismatches;
    int          cycles;

    function automatic logic is_sep(input logic [7:0] c);
        return c != EOL_CH && (c == shadow_cfg.delim_a || c == shadow_cfg.delim_b ||
                               c == shadow_cfg.delim_c || c == shadow_cfg.delim_d);
    endfunction

    function automatic void clear_scan();
        scan_pos       = '0;
        fld_begin      = '0;
        quoted_open    = 1'b0;
        in_quote       = 1'b0;
        close_wait     = 1'b0;
        close_at       = '0;
        kept_fields    = '0;
        dropped_fields = 1'b0;
        quotes_removed = 1'b0;
    endfunction

    // Fills r with the current field; returns 0 when the field is over the limit.
    function automatic bit close_field(inout qft_result_t r);
        int first;
        int len;
        if (kept_fields >= FIELD_LIMIT) begin
            dropped_fields = 1'b1;
            return 1'b0;
        end
        if (quotes_removed) begin
            first = int'(fld_begin) + 1;
            len   = (int'(close_at) >= first) ? int'(close_at) - first : 0;
        end else begin
            first = int'(fld_begin);
            len   = int'(scan_pos) - int'(fld_begin);
        end
        r.field_valid  = 1'b1;
        r.field_start  = first[START_W-1:0];
        r.field_length = len[LEN_W-1:0];
        r.field_index  = kept_fields[INDEX_W-1:0];
        kept_fields++;
        return 1'b1;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        qft_result_t r;
        bit          kept;
        r    = '0;
        kept = 1'b0;
        if (c == EOL_CH) begin
            // end of line settles a pending strip
            if (close_wait) begin
                close_wait     = 1'b0;
                quotes_removed = 1'b1;
                quoted_open    = 1'b0;
            end
            if (quotes_removed || scan_pos != fld_begin || shadow_cfg.keep_final_empty)
                void'(close_field(r));
            r.line_done   = 1'b1;
            r.field_count = kept_fields;
            r.overflow    = dropped_fields;
            field_q.push_back(r);
            clear_scan();
            return;
        end
        // past the line limit everything is ignored, a pending strip included
        if (scan_pos >= LINE_LIMIT - 1)
            return;
        if (close_wait) begin
            close_wait = 1'b0;
            if (is_sep(c)) begin
                quotes_removed = 1'b1;
                quoted_open    = 1'b0;
            end
        end
        if (in_quote) begin
            if (c == QUOTE_CH) begin
                in_quote = 1'b0;
                if (shadow_cfg.strip_quotes && quoted_open && !quotes_removed) begin
                    close_wait = 1'b1;
                    close_at   = scan_pos[9:0];
                end
            end
        end else if (c == QUOTE_CH) begin
            // a quote opens a section even when it is also a delimiter
            if (scan_pos == fld_begin && !quotes_removed)
                quoted_open = 1'b1;
            in_quote = 1'b1;
        end else if (is_sep(c)) begin
            if (quotes_removed || scan_pos != fld_begin || !shadow_cfg.drop_empty)
                kept = close_field(r);
            fld_begin      = 10'(scan_pos + 11'd1);
            quoted_open    = 1'b0;
            quotes_removed = 1'b0;
        end
        scan_pos++;
        if (kept)
            field_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one character per transfer, random gap after each.
    // Prediction runs on the accepting edge with the character just taken.
    // ------------------------------------------------------------------
    int gap_left;
    bit in_calm;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            ch       <= EOL_CH;
            gap_left = 0;
            in_calm  = 1'b0;
        end else begin
            if (in_valid && !in_stall)
                scan_char(ch);
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    ch       <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                    // occasional flip into or out of a stretch with no gaps
                    if ($urandom_range(0, 31) == 0)
                        in_calm = !in_calm;
                    gap_left = in_calm ? 0 : $urandom_range(0, 5);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares each transfer with the oldest expectation,
    // then draws how long to stall. Stalls also start while nothing is
    // offered so that they overlap every stage of the pipeline.
    // ------------------------------------------------------------------
    int          stall_left;
    bit          out_calm;
    qft_result_t want;

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            out_calm   = 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (field_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    mismatches++;
                end else begin
                    want = field_q.pop_front();
                    check_field("field_valid",  want.field_valid,  field_valid);
                    check_field("field_start",  want.field_start,  field_start);
                    check_field("field_length", want.field_length, field_length);
                    check_field("field_index",  want.field_index,  field_index);
                    check_field("line_done",    want.line_done,    line_done);
                    check_field("field_count",  want.field_count,  field_count);
                    check_field("overflow",     want.overflow,     overflow);
                end
                if ($urandom_range(0, 31) == 0)
                    out_calm = !out_calm;
                stall_left = out_calm ? 0 : $urandom_range(0, 5);
            end else if (!out_valid && stall_left == 0 && !out_calm &&
                         $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put(input logic [7:0] c);
        pending_chars.push_back(c);
        queued++;
    endtask

    task automatic put_line(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
        put(EOL_CH);
    endtask

    // Wait for the block to go idle; the extra cycles cover characters
    // still in the input register that yield no result.
    task automatic settle();
        while (pending_chars.size() != 0 || in_valid || field_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input qft_reg_idx_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_cfg(input qft_cfg_t c);
        settle();
        write_reg(REG_DELIM_A,          c.delim_a);
        write_reg(REG_DELIM_B,          c.delim_b);
        write_reg(REG_DELIM_C,          c.delim_c);
        write_reg(REG_DELIM_D,          c.delim_d);
        write_reg(REG_DROP_EMPTY,       {7'd0, c.drop_empty});
        write_reg(REG_STRIP_QUOTES,     {7'd0, c.strip_quotes});
        write_reg(REG_KEEP_FINAL_EMPTY, {7'd0, c.keep_final_empty});
        shadow_cfg = c;
    endtask

    function automatic qft_cfg_t mk_cfg(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic de, input logic sq, input logic kf);
        qft_cfg_t r;
        r.delim_a          = a;
        r.delim_b          = b;
        r.delim_c          = c;
        r.delim_d          = d;
        r.drop_empty       = de;
        r.strip_quotes     = sq;
        r.keep_final_empty = kf;
        return r;
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h20;
            2:       return 8'h2C;
            3:       return QUOTE_CH;
            4:       return 8'hFF;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Mostly well-formed lines (words, quoted fields, empties joined by the
    // live delimiters), some with malformed quoting, some pure noise.
    task automatic queue_random_line();
        logic [7:0] seps[$];
        int         nf;
        int         n;
        int         kind;
        seps = {};
        if (shadow_cfg.delim_a != 0) seps.push_back(shadow_cfg.delim_a);
        if (shadow_cfg.delim_b != 0) seps.push_back(shadow_cfg.delim_b);
        if (shadow_cfg.delim_c != 0) seps.push_back(shadow_cfg.delim_c);
        if (shadow_cfg.delim_d != 0) seps.push_back(shadow_cfg.delim_d);
        if (seps.size() == 0) seps.push_back(8'h20);
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(0, 20);
            repeat (n) put(8'($urandom_range(1, 255)));
        end else begin
            // now and then a line long on fields, to reach the field limit
            nf = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
            for (int i = 0; i < nf; i++) begin
                if (i > 0 || $urandom_range(0, 3) == 0)
                    put(seps[$urandom_range(0, seps.size() - 1)]);
                kind = $urandom_range(0, 5);
                if (kind == 1 || kind == 2) begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        put(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(97, 122)));
                end else if (kind == 3 || kind == 4) begin
                    // quoted field; content may hold delimiters
                    put(QUOTE_CH);
                    n = $urandom_range(0, 5);
                    repeat (n)
                        put(($urandom_range(0, 2) == 0) ? seps[$urandom_range(0, seps.size() - 1)]
                                                        : 8'($urandom_range(65, 90)));
                    if (kind == 4 || $urandom_range(0, 5) != 0)
                        put(QUOTE_CH);
                    if (kind == 4 && $urandom_range(0, 1) == 0)
                        put(8'($urandom_range(97, 122)));   // text after the closing quote
                end else if (kind == 5) begin
                    put(8'($urandom_range(97, 122)));
                    put(QUOTE_CH);                          // quote inside a plain word
                    put(8'($urandom_range(97, 122)));
                end
            end
            if ($urandom_range(0, 4) == 0)
                put(seps[$urandom_range(0, seps.size() - 1)]);
        end
        put(EOL_CH);
    endtask

    task automatic queue_random(input int count);
        int goal;
        goal = queued + count;
        while (queued < goal)
            queue_random_line();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    qft_cfg_t plan[$];

    initial begin
        queued     = 0;
        mismatches = 0;
        cycles     = 0;
        shadow_cfg = mk_cfg(8'h20, 8'h0A, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
        clear_scan();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines under the reset register values.
        put_line("");                    // empty line, nothing kept
        put_line("  a\n");               // leading and trailing empties dropped
        put_line("\"x y\" \"\"");        // quoted delimiter, stripped empty field kept
        put_line("\"a\"b \"c");          // no strip before text, unclosed quote
        put(8'hFF); put(8'h01); put(8'h80); put(8'h7F); put(EOL_CH);

        // Long line: characters past the limit are dropped, and the pending strip of
        // the quoted field before them is settled by the line end.
        for (int i = 0; i < LINE_LIMIT - 5; i++)
            put(8'h78);
        put(8'h20); put(QUOTE_CH); put(8'h71); put(QUOTE_CH);
        put(8'h7A); put(8'h20); put(8'h62); put(8'h20);
        put(EOL_CH);

        // No empties dropped, final empty kept, top-bit delimiter.
        apply_cfg(mk_cfg(8'h2C, 8'h3B, 8'h09, 8'hFF, 1'b0, 1'b1, 1'b1));
        repeat (70) put(8'h2C);          // more empty fields than the limit
        put(EOL_CH);
        put_line("a;;\"b,c\",");
        queue_random(85);

        // Quote doubles as a delimiter.
        apply_cfg(mk_cfg(QUOTE_CH, 8'h20, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
        put_line("\"ab\" c\"d\"\"\"e");
        queue_random(85);

        plan = {};
        plan.push_back(mk_cfg(8'h01, 8'hFF, 8'h2C, 8'h20, 1'b0, 1'b0, 1'b1));
        plan.push_back(mk_cfg(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
        plan.push_back(mk_cfg(8'h20, 8'h0A, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
        plan.push_back(mk_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
        repeat (4)
            plan.push_back(mk_cfg(pick_delim(), pick_delim(), pick_delim(), pick_delim(),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
        foreach (plan[k]) begin
            apply_cfg(plan[k]);
            queue_random(85);
        end

        // Drain: all characters handed over, then the results, then quiet time.
        while (pending_chars.size() != 0 || in_valid)
            @(posedge clk);
        for (int k = 0; k < 2000 && field_q.size() != 0; k++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (field_q.size() != 0) begin
            $error("%0d expected results never arrived", field_q.size());
            mismatches += field_q.size();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
